// File: hdl/ple_pkg.sv
// shared types, codes and constants for the positional list engine
package ple_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int CAP_MAX      = 64;
	localparam int CTL_W        = $clog2(CAP_MAX + 1);
	localparam int OP_W         = 3;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 5;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	localparam logic [1:0] CMD_HOLD = 2'd0;
	localparam logic [1:0] CMD_INS  = 2'd1;
	localparam logic [1:0] CMD_DEL  = 2'd2;
	localparam logic [1:0] CMD_ROT  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] element;
		logic [COUNT_W-1:0]       count;
		logic                     last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [CTL_W-1:0] idx;
		logic [CTL_W-1:0] tail;
	} cell_ctl_t;

endpackage

// File: hdl/positional_list_engine.sv
// top level: control, output register and the chain of list cells
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells that
// shift toward the back on insert and toward the front on delete. Every insert or
// delete transaction returns one result, so such transactions can be accepted on
// consecutive cycles while the output side keeps up. A read_all returns one result
// per element, one per cycle while the output side keeps up, by rotating the
// occupied cells one place per result and sending the front cell; an empty list
// gives one ST_EMPTY result. No input transaction is accepted until the last result
// has been loaded into the output register. An output register decouples the two
// channels, so a new transaction is taken while the previous result is being taken.
module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ple_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ple_pkg::out_item_t out_item
);
	import ple_pkg::*;

	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_READ = 1'b1;

	logic [0:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	cell_ctl_t                ctl;

	logic            slot_free;
	logic            in_fire;
	logic            full;
	logic            empty;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic [STATUS_W-1:0] dec_status;
	logic [1:0]       dec_cmd;
	logic [CTL_W-1:0] dec_idx;
	logic             start_read;
	logic             read_step;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign in_fire   = in_valid && in_ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_c     = CMP_W'(in_item.position);
	assign cnt_c     = CMP_W'(count_q);

	always_comb begin
		dec_status = ST_OK;
		dec_cmd    = CMD_HOLD;
		dec_idx    = '0;
		start_read = 1'b0;
		case (in_item.op)
			OP_INS_FRONT: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_cmd = CMD_INS;
				end
			end
			OP_INS_END: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_cmd = CMD_INS;
					dec_idx = CTL_W'(count_q);
				end
			end
			OP_INS_AT: begin
				if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
					dec_status = ST_BADPOS;
				end else if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_cmd = CMD_INS;
					dec_idx = CTL_W'(in_item.position) - CTL_W'(1);
				end
			end
			OP_DEL_FRONT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_cmd = CMD_DEL;
				end
			end
			OP_DEL_END: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_cmd = CMD_DEL;
					dec_idx = CTL_W'(count_q) - CTL_W'(1);
				end
			end
			OP_DEL_AT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if (pos_c == '0 || pos_c > cnt_c) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_cmd = CMD_DEL;
					dec_idx = CTL_W'(in_item.position) - CTL_W'(1);
				end
			end
			OP_READ_ALL: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					start_read = 1'b1;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	assign read_step = (in_fire && start_read) || ((state_q == S_READ) && slot_free);

	always_comb begin
		ctl.cmd  = CMD_HOLD;
		ctl.idx  = dec_idx;
		ctl.tail = CTL_W'(count_q) - CTL_W'(1);
		if (read_step) begin
			ctl.cmd = CMD_ROT;
		end else if (in_fire) begin
			ctl.cmd = dec_cmd;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = cell_data[0];
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		ple_cell #(
			.INDEX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.ins_value (in_item.value),
			.left      (left_d),
			.right     (right_d),
			.head      (cell_data[0]),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (read_step) begin
				out_valid_q <= 1'b1;
				if (state_q == S_IDLE) begin
					if (count_q != CW'(1)) begin
						state_q <= S_READ;
						rem_q   <= count_q - CW'(1);
					end
				end else begin
					rem_q <= rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
			end else if (in_fire) begin
				out_valid_q <= 1'b1;
				if (dec_cmd == CMD_INS) begin
					count_q <= count_q + CW'(1);
				end else if (dec_cmd == CMD_DEL) begin
					count_q <= count_q - CW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (read_step) begin
			out_q.status  <= ST_OK;
			out_q.element <= cell_data[0];
			out_q.count   <= COUNT_W'(count_q);
			out_q.last    <= (state_q == S_IDLE) ? (count_q == CW'(1)) : (rem_q == CW'(1));
		end else if (in_fire) begin
			out_q.status  <= dec_status;
			out_q.element <= '0;
			out_q.last    <= 1'b1;
			case (dec_cmd)
				CMD_INS: begin
					out_q.count <= COUNT_W'(count_q + CW'(1));
				end
				CMD_DEL: begin
					out_q.count <= COUNT_W'(count_q - CW'(1));
				end
				default: begin
					out_q.count <= COUNT_W'(count_q);
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: hdl/ple_cell.sv
// one storage cell of the list chain
module ple_cell #(
	parameter int INDEX = 0
) (
	input  logic                               clk,
	input  ple_pkg::cell_ctl_t                 ctl,
	input  logic signed [ple_pkg::DATA_W-1:0]  ins_value,
	input  logic signed [ple_pkg::DATA_W-1:0]  left,
	input  logic signed [ple_pkg::DATA_W-1:0]  right,
	input  logic signed [ple_pkg::DATA_W-1:0]  head,
	output logic signed [ple_pkg::DATA_W-1:0]  data
);
	import ple_pkg::*;

	localparam logic [CTL_W-1:0] MY_IDX = CTL_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.cmd)
			CMD_INS: begin
				if (MY_IDX == ctl.idx) begin
					data_d = ins_value;
				end else if (MY_IDX > ctl.idx) begin
					data_d = left;
				end
			end
			CMD_DEL: begin
				if (MY_IDX >= ctl.idx) begin
					data_d = right;
				end
			end
			CMD_ROT: begin
				if (MY_IDX < ctl.tail) begin
					data_d = right;
				end else if (MY_IDX == ctl.tail) begin
					data_d = head;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the positional list engine
`timescale 1ns / 100ps

module tb_top;
	import ple_pkg::*;

	localparam int CAPACITY       = DEF_CAPACITY;
	localparam int RANDOM_ITEMS   = 183;
	localparam int CALM_ITEMS     = 40;
	localparam int HOLD_AT        = 40;
	localparam int HOLD_CYCLES    = 80;
	localparam int PAUSE_AT       = 120;
	localparam int FLIP_EVERY     = 25;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 600;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
		int                       reps;
		bit                       pinned;
		logic [STATUS_W-1:0]      status;
		logic [COUNT_W-1:0]       count;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
	int                       shadow_count = 0;
	out_item_t                pending_results [$];
	out_item_t                want_item;
	plan_row_t                plan [$];
	int                       mismatch_count = 0;
	int                       idle_cycles = 0;
	bit                       calm = 1'b0;
	bit                       hold_req = 1'b0;
	bit                       hold_done = 1'b0;

	positional_list_engine #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic plan_row_t mk_row(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] value, input logic [POS_W-1:0] position,
			input int reps, input bit pinned, input logic [STATUS_W-1:0] status,
			input logic [COUNT_W-1:0] count);
		plan_row_t r;
		r.op       = op;
		r.value    = value;
		r.position = position;
		r.reps     = reps;
		r.pinned   = pinned;
		r.status   = status;
		r.count    = count;
		return r;
	endfunction

	task automatic list_apply(input in_item_t it);
		out_item_t           res;
		logic [STATUS_W-1:0] st;
		int                  idx;
		int                  i;
		bit                  streamed;
		st       = ST_OK;
		streamed = 1'b0;
		res      = '0;
		case (it.op)
			OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
				if (it.op == OP_INS_AT && (it.position == 0 || it.position > shadow_count + 1)) begin
					st = ST_BADPOS;
				end else if (shadow_count >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					if (it.op == OP_INS_FRONT)
						idx = 0;
					else if (it.op == OP_INS_END)
						idx = shadow_count;
					else
						idx = it.position - 1;
					for (i = shadow_count; i > idx; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[idx] = it.value;
					shadow_count++;
				end
			end
			OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
				if (shadow_count == 0) begin
					st = ST_EMPTY;
				end else if (it.op == OP_DEL_AT && (it.position == 0 || it.position > shadow_count)) begin
					st = ST_BADPOS;
				end else begin
					if (it.op == OP_DEL_FRONT)
						idx = 0;
					else if (it.op == OP_DEL_END)
						idx = shadow_count - 1;
					else
						idx = it.position - 1;
					for (i = idx; i + 1 < shadow_count; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_count--;
				end
			end
			OP_READ_ALL: begin
				if (shadow_count == 0) begin
					st = ST_EMPTY;
				end else begin
					streamed = 1'b1;
					for (i = 0; i < shadow_count; i++) begin
						res.status  = ST_OK;
						res.element = shadow_cells[i];
						res.count   = COUNT_W'(shadow_count);
						res.last    = (i == shadow_count - 1);
						pending_results.push_back(res);
					end
				end
			end
			default: begin
			end
		endcase
		if (!streamed) begin
			res.status  = st;
			res.element = '0;
			res.count   = COUNT_W'(shadow_count);
			res.last    = 1'b1;
			pending_results.push_back(res);
		end
	endtask

	task automatic send_item(input in_item_t it, input bit pinned,
			input logic [STATUS_W-1:0] status, input logic [COUNT_W-1:0] count);
		out_item_t typed;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		list_apply(it);
		if (pinned) begin
			typed.status  = status;
			typed.element = '0;
			typed.count   = count;
			typed.last    = 1'b1;
			void'(pending_results.pop_back());
			pending_results.push_back(typed);
		end
	endtask

	task automatic flag_mismatch(input string why, input out_item_t want, input out_item_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display({"tb_top: %s: expected st=%0d el=%0d cnt=%0d last=%0d, ",
				"got st=%0d el=%0d cnt=%0d last=%0d"},
				why, want.status, want.element, want.count, want.last,
				got.status, got.element, got.count, got.last);
	endtask

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, out_item);
			end else begin
				want_item = pending_results.pop_front();
				if (out_item.status !== want_item.status || out_item.element !== want_item.element ||
						out_item.count !== want_item.count || out_item.last !== want_item.last)
					flag_mismatch("wrong result", want_item, out_item);
			end
		end
	end

	// receiver side
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		in_item_t it;
		int       n;
		int       k;
		int       r;
		bit       grow;

		plan.push_back(mk_row(OP_READ_ALL,  0,            0,  1, 1, ST_EMPTY,  0));
		plan.push_back(mk_row(OP_DEL_FRONT, 0,            0,  1, 1, ST_EMPTY,  0));
		plan.push_back(mk_row(OP_DEL_END,   0,            0,  1, 1, ST_EMPTY,  0));
		plan.push_back(mk_row(OP_DEL_AT,    0,            0,  1, 1, ST_EMPTY,  0));
		plan.push_back(mk_row(OP_DEL_AT,    0,            17, 1, 1, ST_EMPTY,  0));
		plan.push_back(mk_row(OP_INS_AT,    5,            0,  1, 1, ST_BADPOS, 0));
		plan.push_back(mk_row(OP_INS_AT,    5,            2,  1, 1, ST_BADPOS, 0));
		plan.push_back(mk_row(OP_INS_FRONT, 32'h7fffffff, 0,  1, 1, ST_OK,     1));
		plan.push_back(mk_row(OP_INS_END,   32'h80000000, 0,  1, 1, ST_OK,     2));
		plan.push_back(mk_row(OP_INS_AT,    -1,           2,  1, 1, ST_OK,     3));
		plan.push_back(mk_row(OP_INS_AT,    0,            4,  1, 1, ST_OK,     4));
		plan.push_back(mk_row(OP_DEL_AT,    0,            0,  1, 1, ST_BADPOS, 4));
		plan.push_back(mk_row(OP_DEL_AT,    0,            5,  1, 1, ST_BADPOS, 4));
		plan.push_back(mk_row(OP_READ_ALL,  0,            0,  1, 0, ST_OK,     0));
		plan.push_back(mk_row(OP_DEL_AT,    0,            2,  1, 1, ST_OK,     3));
		plan.push_back(mk_row(OP_UNUSED,    -1,           17, 1, 1, ST_OK,     3));
		plan.push_back(mk_row(OP_INS_END,   100,          0, 13, 0, ST_OK,     0));
		plan.push_back(mk_row(OP_INS_FRONT, 1,            0,  1, 1, ST_FULL,  16));
		plan.push_back(mk_row(OP_INS_END,   2,            0,  1, 1, ST_FULL,  16));
		plan.push_back(mk_row(OP_INS_AT,    3,            17, 1, 1, ST_FULL,  16));
		plan.push_back(mk_row(OP_INS_AT,    4,            0,  1, 1, ST_BADPOS, 16));
		plan.push_back(mk_row(OP_READ_ALL,  0,            0,  1, 0, ST_OK,     0));
		plan.push_back(mk_row(OP_DEL_AT,    0,            16, 1, 1, ST_OK,    15));
		plan.push_back(mk_row(OP_DEL_FRONT, 0,            0,  1, 1, ST_OK,    14));
		plan.push_back(mk_row(OP_DEL_END,   0,            0,  1, 1, ST_OK,    13));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (k = 0; k < plan[i].reps; k++) begin
				it.op       = plan[i].op;
				it.value    = plan[i].value + k;
				it.position = plan[i].position;
				send_item(it, plan[i].pinned, plan[i].status, plan[i].count);
			end
		end

		grow = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (n % FLIP_EVERY == 0)
				grow = !grow;

			r = $urandom_range(0, 99);
			if (grow)
				it.op = OP_W'((r < 70) ? OP_INS_FRONT + (r % 3) :
					(r < 90) ? OP_DEL_FRONT + (r % 3) :
					(r < 98) ? OP_READ_ALL : OP_UNUSED);
			else
				it.op = OP_W'((r < 30) ? OP_INS_FRONT + (r % 3) :
					(r < 85) ? OP_DEL_FRONT + (r % 3) :
					(r < 97) ? OP_READ_ALL : OP_UNUSED);

			case ($urandom_range(0, 9))
				0: it.value = 32'h7fffffff;
				1: it.value = 32'h80000000;
				default: it.value = $urandom;
			endcase

			if ($urandom_range(0, 4) == 0)
				it.position = POS_W'($urandom_range(0, 17));
			else if (it.op == OP_INS_AT)
				it.position = POS_W'($urandom_range(1, shadow_count + 1));
			else if (it.op == OP_DEL_AT && shadow_count > 0)
				it.position = POS_W'($urandom_range(1, shadow_count));
			else
				it.position = POS_W'($urandom_range(0, 17));

			send_item(it, 1'b0, ST_OK, '0);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: files.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
dv/tb_top.sv
